// ===== rtl/ntt_pkg.sv =====
// Shared types, constants and modular arithmetic helpers for the transform core.
package ntt_pkg;

	// Coefficient width and the prime modulus.
	localparam int DW = 30;
	localparam logic [DW-1:0] Q_MOD = 30'd998244353;
	localparam logic [31:0] Q_MOD2 = 32'd1996488706;

	// Barrett constant floor(2^60 / Q), worked out at elaboration.
	localparam logic [30:0] MU_Q = 31'((64'd1 << 60) / 64'd998244353);

	// Primitive root of order 2^23 (3^119) and its inverse.
	localparam int ROOT_LOG = 23;
	localparam int LVW = 5;
	localparam logic [DW-1:0] ROOT_FWD = 30'd15311432;
	localparam logic [DW-1:0] ROOT_INV = 30'd469870224;

	// Default store size.
	localparam int MAX_LOG_SIZE_DEF = 14;

	// Configuration register indexes.
	localparam logic REG_LOG_SIZE = 1'b0;
	localparam logic REG_INVERSE = 1'b1;

	// Command codes of an input word.
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_RUN = 2'd1,
		CMD_READ = 2'd2
	} ntt_cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ROOT,
		ST_PERM,
		ST_BFLY,
		ST_SCALE,
		ST_DONE
	} ntt_state_t;

	// Sum of two residues, reduced once.
	function automatic logic [DW-1:0] add_q(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, Q_MOD}) ? DW'(s - {1'b0, Q_MOD}) : DW'(s);
	endfunction

	// Difference of two residues, wrapped into the field.
	function automatic logic [DW-1:0] sub_q(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] d;
		d = {1'b0, a} + {1'b0, Q_MOD} - {1'b0, b};
		return (a >= b) ? (a - b) : DW'(d);
	endfunction

endpackage

// ===== rtl/ntt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ntt_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/number_theoretic_transform_core.sv =====
// Radix-2 NTT core over 998244353: a write goes straight to the store; a read result passes the RAM
// read register and then the output register. A run squares the twiddle chain, bit-reverses the
// store, does one read-modify-write butterfly at a time and, for the inverse, scales by 1/N.
// The 4-stage Barrett multiplier sets the butterfly spacing; the single RAM port pair sets the rest.
// A length of one goes straight to done. Reset clears the sequencer, output valid flag and config;
// the coefficient store is left as is and holds nothing defined until written.
module number_theoretic_transform_core
	import ntt_pkg::*;
#(
	parameter int MAX_LOG_SIZE = MAX_LOG_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    command,
	input  logic [13:0]   index,
	input  logic [DW-1:0] value,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [DW-1:0] value_res,
	output logic          run_done,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [3:0]    cfg_data
);

	localparam int AW = MAX_LOG_SIZE;
	localparam int LGW = $clog2(MAX_LOG_SIZE + 1);
	localparam int IW = (MAX_LOG_SIZE > 1) ? $clog2(MAX_LOG_SIZE) : 1;

	ntt_state_t state_q, state_d;

	logic [3:0]     log_size_q;
	logic           inverse_q;
	logic           out_valid_q;
	logic [DW-1:0]  out_value_q;
	logic           out_done_q;

	logic [2:0]     cyc_q;
	logic [LVW-1:0] lvl_q;
	logic [AW-1:0]  i_q;
	logic [AW-1:0]  j_q;
	logic [LGW-1:0] s_q;
	logic [DW-1:0]  tw_q;
	logic [DW-1:0]  wn_q;
	logic [DW-1:0]  u_q;
	logic [DW-1:0]  t_q;
	logic [DW-1:0]  x_q;
	logic [DW-1:0]  rts_q [MAX_LOG_SIZE];

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [DW-1:0]  ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [DW-1:0]  ram_rdata;

	logic [DW-1:0]  mul_a;
	logic [DW-1:0]  mul_b;
	logic [59:0]    p_s1;
	logic [59:0]    p_s2;
	logic [30:0]    qh_s2;
	logic [31:0]    r_s3;
	logic [DW-1:0]  res_s4;
	logic [61:0]    qprod;

	logic           in_fire;
	logic [AW-1:0]  in_idx;
	logic [DW-1:0]  in_red;
	logic [LGW-1:0] lg_eff;
	logic [AW:0]    n_full;
	logic [AW-1:0]  last_idx;
	logic [AW-1:0]  j_last;
	logic [AW-1:0]  half;
	logic [AW-1:0]  hm;
	logic [AW-1:0]  addr_a;
	logic [AW-1:0]  addr_b;
	logic           next_k0;
	logic [AW-1:0]  rev_full;
	logic [AW-1:0]  r_idx;
	logic           swap;
	logic [DW-1:0]  ninv;

	// Handshake: a busy sequencer holds off every word; a pending result holds off run and read words.
	assign in_stall = (state_q != ST_IDLE) ||
		(out_valid_q && (command == CMD_RUN || command == CMD_READ));
	assign in_fire = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign value_res = out_value_q;
	assign run_done = out_done_q;

	// Input word decode.
	assign in_idx = AW'(index);
	assign in_red = (value >= Q_MOD) ? (value - Q_MOD) : value;

	// Transform size and derived index arithmetic.
	assign lg_eff = (32'(log_size_q) > MAX_LOG_SIZE) ? LGW'(MAX_LOG_SIZE) : LGW'(log_size_q);
	assign n_full = (AW+1)'(1) << lg_eff;
	assign last_idx = AW'(n_full - (AW+1)'(1));
	assign j_last = last_idx >> 1;
	assign half = AW'(1) << (s_q - LGW'(1));
	assign hm = half - AW'(1);
	assign addr_a = ((j_q & ~hm) << 1) | (j_q & hm);
	assign addr_b = addr_a | half;
	assign next_k0 = ((j_q + AW'(1)) & hm) == '0;
	assign rev_full = {<<{i_q}};
	assign r_idx = rev_full >> (LGW'(MAX_LOG_SIZE) - lg_eff);
	assign swap = i_q < r_idx;
	assign ninv = Q_MOD - DW'((Q_MOD - DW'(1)) >> lg_eff);

	// Coefficient store.
	ntt_ram #(
		.WIDTH(DW),
		.DEPTH(1 << MAX_LOG_SIZE)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Barrett modular multiplier, four stages.
	assign qprod = 62'(p_s1[59:29]) * 62'(MU_Q);

	always_ff @(posedge clk) begin
		p_s1 <= 60'(mul_a) * 60'(mul_b);
		p_s2 <= p_s1;
		qh_s2 <= qprod[61:31];
		r_s3 <= 32'(p_s2 - 60'(qh_s2) * 60'(Q_MOD));
		if (r_s3 >= Q_MOD2) begin
			res_s4 <= DW'(r_s3 - Q_MOD2);
		end else if (r_s3 >= 32'(Q_MOD)) begin
			res_s4 <= DW'(r_s3 - 32'(Q_MOD));
		end else begin
			res_s4 <= DW'(r_s3);
		end
	end

	// Next-state logic of the run sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && command == CMD_READ) begin
					state_d = ST_READ;
				end else if (in_fire && command == CMD_RUN) begin
					state_d = (lg_eff == '0) ? ST_DONE : ST_ROOT;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_ROOT: begin
				if (cyc_q == 3'd0 && lvl_q == LVW'(1)) begin
					state_d = ST_PERM;
				end
			end
			ST_PERM: begin
				if (i_q == last_idx && ((cyc_q == 3'd0 && !swap) || cyc_q == 3'd3)) begin
					state_d = ST_BFLY;
				end
			end
			ST_BFLY: begin
				if (cyc_q == 3'd7 && j_q == j_last && s_q == lg_eff) begin
					state_d = inverse_q ? ST_SCALE : ST_DONE;
				end
			end
			ST_SCALE: begin
				if (cyc_q == 3'd5 && i_q == last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory port and multiplier operand selection.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = i_q;
		ram_wdata = '0;
		ram_raddr = i_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = in_idx;
				ram_waddr = in_idx;
				ram_wdata = in_red;
				ram_we = in_fire && command == CMD_WRITE;
			end
			ST_ROOT: begin
				mul_a = tw_q;
				mul_b = tw_q;
			end
			ST_PERM: begin
				case (cyc_q)
					3'd1: begin
						ram_raddr = r_idx;
					end
					3'd2: begin
						ram_we = 1'b1;
						ram_wdata = ram_rdata;
					end
					3'd3: begin
						ram_we = 1'b1;
						ram_waddr = r_idx;
						ram_wdata = x_q;
					end
					default: begin
						ram_raddr = i_q;
					end
				endcase
			end
			ST_BFLY: begin
				ram_raddr = addr_a;
				ram_waddr = addr_a;
				case (cyc_q)
					3'd1: begin
						ram_raddr = addr_b;
					end
					3'd2: begin
						mul_a = ram_rdata;
						mul_b = wn_q;
					end
					3'd3: begin
						mul_a = wn_q;
						mul_b = tw_q;
					end
					3'd6: begin
						ram_we = 1'b1;
						ram_wdata = add_q(u_q, res_s4);
					end
					3'd7: begin
						ram_we = 1'b1;
						ram_waddr = addr_b;
						ram_wdata = sub_q(u_q, t_q);
					end
					default: begin
						ram_raddr = addr_a;
					end
				endcase
			end
			ST_SCALE: begin
				if (cyc_q == 3'd1) begin
					mul_a = ram_rdata;
					mul_b = ninv;
				end
				if (cyc_q == 3'd5) begin
					ram_we = 1'b1;
					ram_wdata = res_s4;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers: state, configuration and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			log_size_q <= '0;
			inverse_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_LOG_SIZE: log_size_q <= cfg_data;
					REG_INVERSE: inverse_q <= cfg_data[0];
					default: inverse_q <= inverse_q;
				endcase
			end
			if (state_q == ST_READ || state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_value_q <= ram_rdata;
			out_done_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			out_value_q <= '0;
			out_done_q <= 1'b1;
		end
	end

	// Sequencer counters and butterfly datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cyc_q <= '0;
				lvl_q <= LVW'(ROOT_LOG);
				tw_q <= inverse_q ? ROOT_INV : ROOT_FWD;
			end
			ST_ROOT: begin
				if (cyc_q == 3'd0) begin
					if (32'(lvl_q) <= 32'(lg_eff)) begin
						rts_q[IW'(lvl_q - LVW'(1))] <= tw_q;
					end
					if (lvl_q == LVW'(1)) begin
						i_q <= '0;
					end else begin
						cyc_q <= 3'd1;
					end
				end else if (cyc_q == 3'd4) begin
					tw_q <= res_s4;
					lvl_q <= lvl_q - LVW'(1);
					cyc_q <= '0;
				end else begin
					cyc_q <= cyc_q + 3'd1;
				end
			end
			ST_PERM: begin
				if ((cyc_q == 3'd0 && !swap) || cyc_q == 3'd3) begin
					cyc_q <= '0;
					if (i_q == last_idx) begin
						s_q <= LGW'(1);
						j_q <= '0;
						tw_q <= rts_q[0];
						wn_q <= DW'(1);
					end else begin
						i_q <= i_q + AW'(1);
					end
				end else begin
					if (cyc_q == 3'd1) begin
						x_q <= ram_rdata;
					end
					cyc_q <= cyc_q + 3'd1;
				end
			end
			ST_BFLY: begin
				if (cyc_q == 3'd1) begin
					u_q <= ram_rdata;
				end
				if (cyc_q == 3'd6) begin
					t_q <= res_s4;
				end
				if (cyc_q == 3'd7) begin
					cyc_q <= '0;
					if (j_q == j_last) begin
						i_q <= '0;
						if (s_q != lg_eff) begin
							tw_q <= rts_q[IW'(s_q)];
							s_q <= s_q + LGW'(1);
						end
						j_q <= '0;
						wn_q <= DW'(1);
					end else begin
						j_q <= j_q + AW'(1);
						wn_q <= next_k0 ? DW'(1) : res_s4;
					end
				end else begin
					cyc_q <= cyc_q + 3'd1;
				end
			end
			ST_SCALE: begin
				if (cyc_q == 3'd5) begin
					cyc_q <= '0;
					i_q <= i_q + AW'(1);
				end else begin
					cyc_q <= cyc_q + 3'd1;
				end
			end
			default: begin
				cyc_q <= '0;
			end
		endcase
	end

	// A result is only staged into an empty output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_DONE) |-> !out_valid_q)
		else $error("output word staged over a pending word");

	// A new output word only follows a read or the end of a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_DONE))
		else $error("output word raised without a source");

	// The twiddle squaring chain never runs below level one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> (lvl_q != '0))
		else $error("twiddle level counter underflow");

endmodule

// ===== bench/number_theoretic_transform_core_checker.sv =====
// Checker for the transform core: tracks the store, predicts each result word and compares it.
`timescale 1ns / 1ps
module number_theoretic_transform_core_checker
	import ntt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  logic [1:0]    command,
	input  logic [13:0]   index,
	input  logic [DW-1:0] value,
	input  logic          out_valid,
	input  logic          out_stall,
	input  logic [DW-1:0] value_res,
	input  logic          run_done,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [3:0]    cfg_data,
	output int            errors,
	output int            pending
);

	localparam int LOG_CAP = 14;
	localparam int DEPTH = 1 << LOG_CAP;
	localparam longint unsigned PRIME = 64'd998244353;
	localparam longint unsigned GENERATOR = 64'd3;

	// Mirror of the coefficient store and of the configuration.
	logic [DW-1:0] coeffs [DEPTH];
	logic [3:0]    size_log;
	logic          inv_mode;

	// Expected result words, newest at the front and oldest at the back.
	logic [DW-1:0] want_value [$];
	logic          want_done [$];

	function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
		return (a * b) % PRIME;
	endfunction

	function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e);
		longint unsigned r;
		r = 1;
		b = b % PRIME;
		while (e != 0) begin
			if (e[0]) r = mod_mul(r, b);
			b = mod_mul(b, b);
			e = e >> 1;
		end
		return r;
	endfunction

	// In-place transform of the first 2^size_log entries of the mirror, size_log capped at 14.
	task automatic transform_mirror();
		int lg, n, r, half, len, base;
		longint unsigned w, wn, u, v, ninv;
		logic [DW-1:0] t;
		lg = (size_log > LOG_CAP) ? LOG_CAP : int'(size_log);
		n = 1 << lg;
		if (n == 1) return;
		// Bit-reversal permutation.
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int k = 0; k < lg; k++)
				r |= ((i >> k) & 1) << (lg - 1 - k);
			if (i < r) begin
				t = coeffs[i];
				coeffs[i] = coeffs[r];
				coeffs[r] = t;
			end
		end
		// Butterfly stages.
		for (len = 2; len <= n; len = len << 1) begin
			half = len >> 1;
			w = mod_pow(GENERATOR, (PRIME - 1) / len);
			if (inv_mode) w = mod_pow(w, PRIME - 2);
			for (base = 0; base < n; base += len) begin
				wn = 1;
				for (int k = 0; k < half; k++) begin
					u = coeffs[base + k];
					v = mod_mul(coeffs[base + k + half], wn);
					coeffs[base + k] = DW'((u + v) % PRIME);
					coeffs[base + k + half] = DW'((u + PRIME - v) % PRIME);
					wn = mod_mul(wn, w);
				end
			end
		end
		// Inverse scaling by 1/N.
		if (inv_mode) begin
			ninv = mod_pow(n, PRIME - 2);
			for (int i = 0; i < n; i++)
				coeffs[i] = DW'(mod_mul(coeffs[i], ninv));
		end
	endtask

	assign pending = want_value.size();

	// Watch configuration, input words and result words.
	always @(posedge clk or negedge arst_n) begin
		longint unsigned v;
		logic [DW-1:0] ev;
		logic ed;
		int bad;
		if (!arst_n) begin
			size_log <= '0;
			inv_mode <= 1'b0;
			errors <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				if (cfg_index == REG_LOG_SIZE) size_log <= cfg_data;
				else inv_mode <= cfg_data[0];
			end
			if (in_valid && !in_stall) begin
				case (command)
					CMD_WRITE: begin
						v = value;
						if (v >= PRIME) v = v - PRIME;
						coeffs[index] = DW'(v);
					end
					CMD_RUN: begin
						transform_mirror();
						want_value.push_front('0);
						want_done.push_front(1'b1);
					end
					CMD_READ: begin
						want_value.push_front(coeffs[index]);
						want_done.push_front(1'b0);
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (want_value.size() == 0) begin
					$error("result word with nothing expected: value_res %0d run_done %0d",
						value_res, run_done);
					bad = bad + 1;
				end else begin
					ev = want_value.pop_back();
					ed = want_done.pop_back();
					if (value_res !== ev) begin
						$error("value_res: expected %0d, actual %0d", ev, value_res);
						bad = bad + 1;
					end
					if (run_done !== ed) begin
						$error("run_done: expected %0d, actual %0d", ed, run_done);
						bad = bad + 1;
					end
				end
			end
			errors <= errors + bad;
		end
	end

endmodule

// ===== bench/number_theoretic_transform_core_tb.sv =====
// Testbench top for the transform core: stimulus, output stalls and the final verdict.
`timescale 1ns / 1ps
module number_theoretic_transform_core_tb;
	import ntt_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STORE_DEPTH = 1 << 14;
	localparam logic [DW-1:0] TOP_VALUE = '1;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [1:0]    command = CMD_WRITE;
	logic [13:0]   index = '0;
	logic [DW-1:0] value = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [DW-1:0] value_res;
	logic          run_done;
	logic          cfg_we = 1'b0;
	logic          cfg_index = REG_LOG_SIZE;
	logic [3:0]    cfg_data = '0;
	int            errors;
	int            pending;

	// Stimulus bookkeeping: which entries hold a defined value.
	bit written [STORE_DEPTH];
	int written_list [$];
	int burst_left = 0;
	int cur_size = 1;

	number_theoretic_transform_core dut (.*);

	number_theoretic_transform_core_checker checker_i (.*);

	always #5 clk = ~clk;

	// Safety limit on the whole run.
	initial begin
		#80ms;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver stalls: shifting random patterns, and one long hold-off.
	initial begin
		int mode, span;
		@(posedge arst_n);
		repeat (2500) @(negedge clk) out_stall = ($urandom_range(0, 1) == 1);
		for (int i = 0; i < 400; i++) @(negedge clk) out_stall = 1'b1;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(32, 96);
			repeat (span) @(negedge clk) begin
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					default: out_stall = ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Offer one word in bursts with random gaps; returns after it is accepted.
	task automatic send(logic [1:0] cmd, int idx, logic [DW-1:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		command = cmd;
		index = 14'(idx);
		value = val;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (cmd == CMD_WRITE && !written[idx]) begin
			written[idx] = 1'b1;
			written_list.push_front(idx);
		end
	endtask

	// Drain the block, then write one register.
	task automatic set_reg(logic idx, logic [3:0] data);
		in_valid = 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_LOG_SIZE) cur_size = 1 << ((data > 14) ? 14 : data);
	endtask

	function automatic logic [DW-1:0] rand_value();
		return DW'($urandom());
	endfunction

	function automatic int rand_written();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	initial begin
		int pick, idx;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: length one, value extremes, reduction, unused code, top index.
		send(CMD_WRITE, 0, Q_MOD - 1);
		send(CMD_WRITE, 1, TOP_VALUE);
		send(CMD_WRITE, 2, Q_MOD);
		send(CMD_WRITE, STORE_DEPTH - 1, '0);
		send(CMD_UNUSED, 1, rand_value());
		send(CMD_RUN, 0, '0);
		send(CMD_READ, 0, '0);
		send(CMD_READ, 1, '0);
		send(CMD_READ, 2, '0);
		send(CMD_READ, STORE_DEPTH - 1, '0);
		set_reg(REG_INVERSE, 4'd1);
		send(CMD_RUN, 0, '0);
		send(CMD_READ, 0, '0);
		// Directed: length four forward and back.
		set_reg(REG_LOG_SIZE, 4'd2);
		for (int i = 0; i < 4; i++) send(CMD_WRITE, i, rand_value());
		set_reg(REG_INVERSE, 4'd0);
		send(CMD_RUN, 0, '0);
		set_reg(REG_INVERSE, 4'd1);
		send(CMD_RUN, 0, '0);
		for (int i = 0; i < 4; i++) send(CMD_READ, i, '0);

		// Random phases over small lengths and both directions.
		for (int ph = 0; ph < 8; ph++) begin
			set_reg(REG_LOG_SIZE, (ph == 0) ? 4'd1 : 4'($urandom_range(0, 7)));
			set_reg(REG_INVERSE, 4'($urandom_range(0, 1)));
			for (int i = 0; i < cur_size; i++)
				if (!written[i]) send(CMD_WRITE, i, rand_value());
			for (int n = 0; n < 150; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, STORE_DEPTH - 1)
						: $urandom_range(0, cur_size - 1);
					send(CMD_WRITE, idx, rand_value());
				end else if (pick < 85) begin
					send(CMD_READ, rand_written(), rand_value());
				end else if (pick < 91) begin
					send(CMD_RUN, $urandom_range(0, STORE_DEPTH - 1), rand_value());
				end else begin
					send(CMD_UNUSED, $urandom_range(0, STORE_DEPTH - 1), rand_value());
				end
			end
		end

		// Oversized length register: store traffic up to the top of the index range.
		set_reg(REG_LOG_SIZE, 4'd15);
		set_reg(REG_INVERSE, 4'd1);
		send(CMD_WRITE, STORE_DEPTH - 1, rand_value());
		for (int n = 0; n < 20; n++) send(CMD_READ, rand_written(), '0);
		send(CMD_READ, STORE_DEPTH - 1, '0);

		// Drain and give the verdict.
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
